// ===== rtl/core/b2da_pkg.sv =====
// Shared widths, ASCII codes and controller state type for the decimal text converter.
package b2da_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * 4;
    localparam int CHAR_W  = 6;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_START = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/b2da_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module b2da_dabble (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [b2da_pkg::VALUE_W-1:0]  mag,
    output logic                          done,
    output logic [b2da_pkg::BCD_W-1:0]    bcd
);

    logic [b2da_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [b2da_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [b2da_pkg::BCD_W-1:0]   adj;
    logic [b2da_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         last_bit;

    assign last_bit = busy_reg && (cnt_reg == {b2da_pkg::CNT_W{1'b1}});

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
            bin_next = {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last_bit) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = last_bit;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Top level: 32-bit word to decimal ASCII text, one character per output word.
//
// Input stream (s_): one word per conversion. s_tdata carries the value,
// s_tuser[0] selects signed mode (1: two's complement, 0: unsigned).
// Output stream (m_): one ASCII character per word in m_tdata[5:0],
// most significant digit first; m_tlast marks the final character.
// A sign '-' leads negative words in signed mode; zero gives "0";
// leading zeros are dropped, so a word yields 1 to 11 characters.
//
// Timing: the word is taken when s_tvalid and s_tready are high. The
// serial BCD converter then shifts in all 32 bits, one bit per cycle,
// the ST_START state locates the top digit, and characters then go out
// one per cycle while the receiver is ready. s_tready is high only while
// no word is in work, and stays high while the last character still
// waits in the output register.
// Reset (aresetn low, synchronous) drops any word in work and empties
// the output register. When m_tready is low the character is held and
// the controller waits; nothing is lost.
module binary_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] signed_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic        m_tlast    // last
);

    b2da_pkg::state_t state_reg, state_next;

    logic                          neg_reg, neg_next;
    logic [b2da_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          m_valid_reg, m_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                          last_reg, last_next;

    logic                          in_fire;
    logic                          in_neg;
    logic [b2da_pkg::VALUE_W-1:0]  in_mag;
    logic                          conv_done;
    logic [b2da_pkg::BCD_W-1:0]    bcd;
    logic [b2da_pkg::POS_W-1:0]    top_idx;
    logic [3:0]                    digit;
    logic                          out_free;

    assign s_tready = (state_reg == b2da_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // negative only in signed mode with the sign bit set; the magnitude of
    // the most negative word still fits in 32 unsigned bits
    assign in_neg = s_tuser[0] && s_tdata[31];
    assign in_mag = in_neg ? (~s_tdata + 32'd1) : s_tdata;

    b2da_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .mag     (in_mag),
        .done    (conv_done),
        .bcd     (bcd)
    );

    // highest nonzero digit; zero word falls back to the units digit
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                top_idx = b2da_pkg::POS_W'(i);
            end
        end
    end

    assign digit    = bcd[pos_reg*4 +: 4];
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        pos_next     = pos_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                if (in_fire) begin
                    neg_next   = in_neg;
                    state_next = b2da_pkg::ST_CONV;
                end
            end
            b2da_pkg::ST_CONV: begin
                if (conv_done) begin
                    state_next = b2da_pkg::ST_START;
                end
            end
            b2da_pkg::ST_START: begin
                pos_next   = top_idx;
                state_next = neg_reg ? b2da_pkg::ST_SIGN : b2da_pkg::ST_EMIT;
            end
            b2da_pkg::ST_SIGN: begin
                if (out_free) begin
                    char_next    = b2da_pkg::ASCII_MINUS;
                    last_next    = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT: begin
                if (out_free) begin
                    char_next    = b2da_pkg::ASCII_ZERO + {2'b00, digit};
                    last_next    = (pos_reg == '0);
                    m_valid_next = 1'b1;
                    if (pos_reg == '0) begin
                        state_next = b2da_pkg::ST_IDLE;
                    end else begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= b2da_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg  <= neg_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, char_reg};
    assign m_tlast  = last_reg;

endmodule
